/* rtl/spindle_speed_phase_monitor_assert.svh */
// Assertion macros shared by the spindle speed and phase monitor RTL.
`ifndef SPINDLE_SPEED_PHASE_MONITOR_ASSERT_SVH
`define SPINDLE_SPEED_PHASE_MONITOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define SSPM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define SSPM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sspm_pkg.sv */
// Types, widths and codes shared by the spindle speed and phase monitor.
`default_nettype none

package sspm_pkg;

  // Field and datapath widths
  localparam int COUNT_WIDTH = 32;
  localparam int RPM_WIDTH   = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int FIELD_W     = 16;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [CFG_W-1:0] MS_PER_MIN = 16'd60000;

  // Shared multiplier: A operand holds the count delta magnitude or the time delta
  localparam int MUL_A_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;
  localparam int MUL_P_W = MUL_A_W + CFG_W;
  localparam int NUM_W   = COUNT_WIDTH + CFG_W;        // |delta| * 60000
  localparam int DEN_W   = TIME_W + CFG_W;             // dt * counts per turn
  localparam int N_W     = (((NUM_W + 1) > DEN_W) ? (NUM_W + 1) : DEN_W) + 1;
  localparam int D2_W    = DEN_W + 1;                  // 2 * den
  localparam int DSH_W   = D2_W + RPM_WIDTH - 1;       // 2 * den, aligned to top quotient bit
  localparam int UNIT_W  = ((DSH_W + 1) > N_W) ? (DSH_W + 1) : N_W;
  localparam int LVL_W   = (RPM_WIDTH > CFG_W) ? RPM_WIDTH : CFG_W;

  localparam int PH_CNT_W  = $clog2(COUNT_WIDTH);
  localparam int RPM_CNT_W = $clog2(RPM_WIDTH);

  localparam logic [RPM_WIDTH-1:0] RPM_MAX = {RPM_WIDTH{1'b1}};

  // Stream payload widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_CNT_PER_TURN    = 3'd1,
    REG_PHASE_MODULUS   = 3'd2,
    REG_RPM_ON_LEVEL    = 3'd3,
    REG_RPM_OFF_LEVEL   = 3'd4
  } sspm_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_PHASE,
    ST_PH_FIX,
    ST_PREP,
    ST_SAT,
    ST_RPM,
    ST_FINAL,
    ST_DONE
  } sspm_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] sample_interval;
    logic [CFG_W-1:0] cnt_per_turn;
    logic [CFG_W-1:0] phase_modulus;
    logic [CFG_W-1:0] rpm_on_level;
    logic [CFG_W-1:0] rpm_off_level;
  } sspm_cfg_t;

  typedef struct packed {
    logic               sampled;
    logic [FIELD_W-1:0] phase;
    logic [FIELD_W-1:0] rpm;
    logic               show_rpm;
  } sspm_res_t;

endpackage

`default_nettype wire

/* rtl/sspm_core.sv */
// Sequencer and shared multiply / compare-subtract datapath for one sample.
`default_nettype none

module sspm_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sspm_pkg::sspm_cfg_t                    cfg_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [sspm_pkg::TIME_W-1:0]            now_ms_i,
  input  logic [sspm_pkg::COUNT_WIDTH-1:0]       count_i,
  output logic                                   res_valid_o,
  input  logic                                   res_ready_i,
  output sspm_pkg::sspm_res_t                    res_o
);

  localparam int CW = sspm_pkg::COUNT_WIDTH;
  localparam int RW = sspm_pkg::RPM_WIDTH;

  sspm_pkg::sspm_state_e state_q, state_d;

  // Model state
  logic [sspm_pkg::TIME_W-1:0]   last_ms_q, last_ms_d;
  logic [CW-1:0]                 last_cnt_q, last_cnt_d;
  logic [sspm_pkg::FIELD_W-1:0]  held_phase_q, held_phase_d;
  logic [RW-1:0]                 held_rpm_q, held_rpm_d;
  logic                          show_q, show_d;

  // Working registers
  logic [sspm_pkg::TIME_W-1:0]   now_q, now_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [sspm_pkg::TIME_W-1:0]   dt_q, dt_d;
  logic                          sampled_q, sampled_d;
  logic [CW-1:0]                 mag_q, mag_d;
  logic [CW-1:0]                 absc_q, absc_d;
  logic                          cneg_q, cneg_d;
  logic [sspm_pkg::NUM_W-1:0]    num_q, num_d;
  logic [sspm_pkg::DEN_W-1:0]    den_q, den_d;
  logic                          den_zero_q, den_zero_d;
  logic [sspm_pkg::FIELD_W-1:0]  ph_rem_q, ph_rem_d;
  logic [sspm_pkg::PH_CNT_W-1:0] ph_step_q, ph_step_d;
  logic [sspm_pkg::N_W-1:0]      n_q, n_d;
  logic [sspm_pkg::DSH_W-1:0]    dsh_q, dsh_d;
  logic [RW-1:0]                 quo_q, quo_d;
  logic [sspm_pkg::RPM_CNT_W-1:0] rpm_step_q, rpm_step_d;
  logic                          sat_q, sat_d;

  // Shared arithmetic
  logic [sspm_pkg::MUL_A_W-1:0]  mul_a;
  logic [sspm_pkg::CFG_W-1:0]    mul_b;
  logic [sspm_pkg::MUL_P_W-1:0]  mul_p;
  logic [sspm_pkg::UNIT_W-1:0]   sub_a, sub_b;
  logic [sspm_pkg::UNIT_W:0]     sub_diff;
  logic                          sub_ge;

  logic [sspm_pkg::TIME_W-1:0]   dt_w;
  logic [CW-1:0]                 delta_fw, delta_bw;
  logic [sspm_pkg::FIELD_W:0]    ph_trial;
  logic [RW-1:0]                 rpm_res;
  logic [sspm_pkg::LVL_W-1:0]    rpm_lvl;

  assign mul_p    = sspm_pkg::MUL_P_W'(mul_a) * sspm_pkg::MUL_P_W'(mul_b);
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[sspm_pkg::UNIT_W];

  assign dt_w     = now_ms_i - last_ms_q;
  assign delta_fw = cnt_q - last_cnt_q;
  assign delta_bw = last_cnt_q - cnt_q;
  assign ph_trial = {ph_rem_q, absc_q[CW-1]};

  // Final rpm: overflow goes to full scale; a zero denominator gives zero if the count did not move, else full scale
  always_comb begin
    if (den_zero_q) begin
      rpm_res = (mag_q == '0) ? '0 : sspm_pkg::RPM_MAX;
    end else if (sat_q) begin
      rpm_res = sspm_pkg::RPM_MAX;
    end else begin
      rpm_res = quo_q;
    end
    rpm_lvl = sspm_pkg::LVL_W'(rpm_res);
  end

  // Next state and datapath
  always_comb begin
    state_d      = state_q;
    last_ms_d    = last_ms_q;
    last_cnt_d   = last_cnt_q;
    held_phase_d = held_phase_q;
    held_rpm_d   = held_rpm_q;
    show_d       = show_q;
    now_d        = now_q;
    cnt_d        = cnt_q;
    dt_d         = dt_q;
    sampled_d    = sampled_q;
    mag_d        = mag_q;
    absc_d       = absc_q;
    cneg_d       = cneg_q;
    num_d        = num_q;
    den_d        = den_q;
    den_zero_d   = den_zero_q;
    ph_rem_d     = ph_rem_q;
    ph_step_d    = ph_step_q;
    n_d          = n_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    rpm_step_d   = rpm_step_q;
    sat_d        = sat_q;
    mul_a        = '0;
    mul_b        = '0;
    sub_a        = '0;
    sub_b        = '0;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      sspm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          now_d     = now_ms_i;
          cnt_d     = count_i;
          dt_d      = dt_w;
          sampled_d = (dt_w >= sspm_pkg::TIME_W'(cfg_i.sample_interval));
          state_d   = (dt_w >= sspm_pkg::TIME_W'(cfg_i.sample_interval)) ?
                      sspm_pkg::ST_MAG : sspm_pkg::ST_DONE;
        end
      end

      // Count delta magnitude and count magnitude, both subtractions in parallel
      sspm_pkg::ST_MAG: begin
        mag_d     = delta_fw[CW-1] ? delta_bw : delta_fw;
        absc_d    = cnt_q[CW-1] ? (CW'(0) - cnt_q) : cnt_q;
        cneg_d    = cnt_q[CW-1];
        ph_rem_d  = '0;
        ph_step_d = sspm_pkg::PH_CNT_W'(CW - 1);
        state_d   = sspm_pkg::ST_MUL_NUM;
      end

      sspm_pkg::ST_MUL_NUM: begin
        mul_a   = sspm_pkg::MUL_A_W'(mag_q);
        mul_b   = sspm_pkg::MS_PER_MIN;
        num_d   = mul_p[sspm_pkg::NUM_W-1:0];
        state_d = sspm_pkg::ST_MUL_DEN;
      end

      sspm_pkg::ST_MUL_DEN: begin
        mul_a   = sspm_pkg::MUL_A_W'(dt_q);
        mul_b   = cfg_i.cnt_per_turn;
        den_d   = mul_p[sspm_pkg::DEN_W-1:0];
        state_d = sspm_pkg::ST_PHASE;
      end

      // Restoring division |count| mod modulus, one bit per cycle
      sspm_pkg::ST_PHASE: begin
        sub_a     = sspm_pkg::UNIT_W'(ph_trial);
        sub_b     = sspm_pkg::UNIT_W'(cfg_i.phase_modulus);
        ph_rem_d  = sub_ge ? sub_diff[sspm_pkg::FIELD_W-1:0]
                           : ph_trial[sspm_pkg::FIELD_W-1:0];
        absc_d    = absc_q << 1;
        ph_step_d = ph_step_q - 1'b1;
        if (ph_step_q == '0) begin
          state_d = sspm_pkg::ST_PH_FIX;
        end
      end

      // Floor modulo: a negative count with a nonzero remainder wraps up; a zero modulus gives zero
      sspm_pkg::ST_PH_FIX: begin
        sub_a = sspm_pkg::UNIT_W'(cfg_i.phase_modulus);
        sub_b = sspm_pkg::UNIT_W'(ph_rem_q);
        if (cfg_i.phase_modulus == '0) begin
          ph_rem_d = '0;
        end else if (cneg_q && (ph_rem_q != '0)) begin
          ph_rem_d = sub_diff[sspm_pkg::FIELD_W-1:0];
        end
        state_d = sspm_pkg::ST_PREP;
      end

      // Rounding numerator 2*num + den, divisor 2*den aligned to the top quotient bit
      sspm_pkg::ST_PREP: begin
        n_d        = sspm_pkg::N_W'({num_q, 1'b0}) + sspm_pkg::N_W'(den_q);
        dsh_d      = sspm_pkg::DSH_W'({den_q, 1'b0}) << (RW - 1);
        den_zero_d = (den_q == '0);
        quo_d      = '0;
        rpm_step_d = sspm_pkg::RPM_CNT_W'(RW - 1);
        state_d    = sspm_pkg::ST_SAT;
      end

      // Quotient would not fit: saturate and skip the division; a zero denominator also skips it
      sspm_pkg::ST_SAT: begin
        sub_a = sspm_pkg::UNIT_W'(n_q);
        sub_b = sspm_pkg::UNIT_W'({dsh_q, 1'b0});
        sat_d = sub_ge;
        if (sub_ge || den_zero_q) begin
          state_d = sspm_pkg::ST_FINAL;
        end else begin
          state_d = sspm_pkg::ST_RPM;
        end
      end

      sspm_pkg::ST_RPM: begin
        sub_a      = sspm_pkg::UNIT_W'(n_q);
        sub_b      = sspm_pkg::UNIT_W'(dsh_q);
        if (sub_ge) begin
          n_d = sub_diff[sspm_pkg::N_W-1:0];
        end
        quo_d      = {quo_q[RW-2:0], sub_ge};
        dsh_d      = dsh_q >> 1;
        rpm_step_d = rpm_step_q - 1'b1;
        if (rpm_step_q == '0) begin
          state_d = sspm_pkg::ST_FINAL;
        end
      end

      // Commit sample and apply hysteresis
      sspm_pkg::ST_FINAL: begin
        held_rpm_d   = rpm_res;
        held_phase_d = ph_rem_q;
        if (!show_q && (rpm_lvl >= sspm_pkg::LVL_W'(cfg_i.rpm_on_level))) begin
          show_d = 1'b1;
        end else if (show_q && (rpm_lvl <= sspm_pkg::LVL_W'(cfg_i.rpm_off_level))) begin
          show_d = 1'b0;
        end
        last_ms_d  = now_q;
        last_cnt_d = cnt_q;
        state_d    = sspm_pkg::ST_DONE;
      end

      sspm_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sspm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sspm_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.sampled  = sampled_q;
  assign res_o.phase    = held_phase_q;
  assign res_o.rpm      = sspm_pkg::FIELD_W'(held_rpm_q);
  assign res_o.show_rpm = show_q;

  // Control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sspm_pkg::ST_IDLE;
      last_ms_q    <= '0;
      last_cnt_q   <= '0;
      held_phase_q <= '0;
      held_rpm_q   <= '0;
      show_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_ms_q    <= last_ms_d;
      last_cnt_q   <= last_cnt_d;
      held_phase_q <= held_phase_d;
      held_rpm_q   <= held_rpm_d;
      show_q       <= show_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    cnt_q      <= cnt_d;
    dt_q       <= dt_d;
    sampled_q  <= sampled_d;
    mag_q      <= mag_d;
    absc_q     <= absc_d;
    cneg_q     <= cneg_d;
    num_q      <= num_d;
    den_q      <= den_d;
    den_zero_q <= den_zero_d;
    ph_rem_q   <= ph_rem_d;
    ph_step_q  <= ph_step_d;
    n_q        <= n_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    rpm_step_q <= rpm_step_d;
    sat_q      <= sat_d;
  end

endmodule

`default_nettype wire

/* rtl/spindle_speed_phase_monitor.sv */
// Spindle speed and phase monitor: top level with config registers and output register.
//
// Input stream (s_axis): one beat per reading, a millisecond timestamp and the
// extended encoder count. Output stream (m_axis): one beat per input beat, with
// tuser set when that reading produced a new speed sample; otherwise the held
// phase, rpm and show flag are repeated.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 sample interval, 1 counts per turn, 2 phase modulus, 3 on level,
// 4 off level); write only while no beat is in flight.
// Sequencing: a sampled beat runs a 32-step remainder loop and a 16-step quotient
// loop on one shared compare-subtract unit; the quotient loop is skipped when rpm
// saturates or the denominator is zero, and an unsampled beat skips both loops.
// s_axis_tready rises at the edge that moves the result into the output register,
// so a new input beat is taken only after the previous result has left the core.
// Reset clears the held values, the last sample time and count, and loads the
// register defaults. If m_axis_tready is low the result waits in the output
// register while the next input beat is taken and processed; that beat's result
// then waits in the core until the register frees.
`default_nettype none
`include "spindle_speed_phase_monitor_assert.svh"

module spindle_speed_phase_monitor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Config write port
  input  logic                                  cfg_we_i,
  input  logic [sspm_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [sspm_pkg::CFG_W-1:0]            cfg_wdata_i,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [sspm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // now_ms[31:0], total_count[63:32]
  // Output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [sspm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // phase[15:0], rpm[31:16],
                                                               // show_rpm[32], zero[39:33]
  output logic                                  m_axis_tuser   // sampled[0]
);

  sspm_pkg::sspm_cfg_t cfg_q, cfg_d;
  sspm_pkg::sspm_res_t res;
  sspm_pkg::sspm_res_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                res_valid;
  logic                res_ready;

  // Config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sspm_pkg::sspm_reg_e'(cfg_addr_i))
        sspm_pkg::REG_SAMPLE_INTERVAL: cfg_d.sample_interval = cfg_wdata_i;
        sspm_pkg::REG_CNT_PER_TURN:    cfg_d.cnt_per_turn    = cfg_wdata_i;
        sspm_pkg::REG_PHASE_MODULUS:   cfg_d.phase_modulus   = cfg_wdata_i;
        sspm_pkg::REG_RPM_ON_LEVEL:    cfg_d.rpm_on_level    = cfg_wdata_i;
        sspm_pkg::REG_RPM_OFF_LEVEL:   cfg_d.rpm_off_level   = cfg_wdata_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval <= 16'd100;
      cfg_q.cnt_per_turn    <= 16'd1600;
      cfg_q.phase_modulus   <= 16'd1600;
      cfg_q.rpm_on_level    <= 16'd50;
      cfg_q.rpm_off_level   <= 16'd30;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sspm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .now_ms_i    (s_axis_tdata[sspm_pkg::TIME_W-1:0]),
    .count_i     (s_axis_tdata[32 +: sspm_pkg::COUNT_WIDTH]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: takes a result whenever it is empty or being drained
  assign res_ready = ~out_valid_q | m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.sampled;
  assign m_axis_tdata  = {7'b0, out_q.show_rpm, out_q.rpm, out_q.phase};

  // Checks
  `SSPM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while previous beat still in work")
  `SSPM_ASSERT_IMP(a_no_accept_with_pending_result, res_valid, !s_axis_tready, "input ready while a result waits in the core")
  `SSPM_ASSERT_NEXT(a_result_reaches_output, res_valid && res_ready, m_axis_tvalid, "handed-off result missing from output register")

endmodule

`default_nettype wire
